>>> sv/egbr_pkg.sv
// Package for the Exp-Golomb bit reader: item mode codes and the
// command and status structs between the controller and the datapath.
// No dependencies.
`default_nettype none
package egbr_pkg;

    typedef enum logic [2:0] {
        MODE_LOAD    = 3'd0,
        MODE_RESTART = 3'd1,
        MODE_READ    = 3'd2,
        MODE_PEEK    = 3'd3,
        MODE_SKIP    = 3'd4,
        MODE_ALIGN   = 3'd5,
        MODE_UE      = 3'd6,
        MODE_SE      = 3'd7
    } mode_t;

    localparam int unsigned OFFSET_W = 16;
    localparam int unsigned VALUE_W  = 32;
    localparam logic [4:0]  PREFIX_MAX = 5'd31;

    typedef struct packed {
        logic start;
        logic addr;
        logic data;
        logic publish;
    } egbr_cmd_t;

    typedef struct packed {
        logic needs_bits;
        logic at_end;
        logic last_bit;
    } egbr_stat_t;

endpackage
`default_nettype wire

>>> sv/egbr_if.sv
// Channel interfaces of the Exp-Golomb bit reader: request, response and
// configuration write. No dependencies.
`default_nettype none
interface egbr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] count;
    logic [11:0] byte_index;
    logic [7:0]  byte_value;
    modport source (output valid, mode, count, byte_index, byte_value, input ready);
    modport sink (input valid, mode, count, byte_index, byte_value, output ready);
endinterface

interface egbr_rsp_if;
    logic               valid;
    logic               ready;
    logic [31:0]        value;
    logic signed [31:0] signed_value;
    logic               exhausted;
    logic               code_error;
    logic [15:0]        bit_position;
    logic signed [16:0] bits_left;
    modport source (output valid, value, signed_value, exhausted, code_error,
                    bit_position, bits_left, input ready);
    modport sink (input valid, value, signed_value, exhausted, code_error,
                  bit_position, bits_left, output ready);
endinterface

interface egbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> sv/exp_golomb_bit_reader_core.sv
// Top level of the Exp-Golomb bit reader: controller plus datapath.
// Depends on egbr_pkg, egbr_if, egbr_ctrl and egbr_datapath.
//
//   channel  role    beat contents
//   req      sink    mode, count, byte_index, byte_value
//   rsp      source  value, signed_value, exhausted, code_error, bit_position, bits_left
//   cfg      sink    stream_length_bits (always ready)
//
// Load, restart, skip and align go from the idle state straight to the publish state.
// Read, peek and Exp-Golomb items pass through an address and a data state for each bit
// fetched, set by one buffer read per bit through the registered memory port.
// Reset clears the bit offset and the stream length; the buffer is not cleared.
// A new request beat is accepted while an earlier result waits on rsp.
`default_nettype none
module exp_golomb_bit_reader_core
    import egbr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES   = 4096,
    parameter int unsigned MAX_FIELD_BITS = 32
)
(
    input wire logic    clk,
    input wire logic    rst_n,
    egbr_req_if.sink    req,
    egbr_rsp_if.source  rsp,
    egbr_cfg_if.sink    cfg
);

    egbr_cmd_t  cmd;
    egbr_stat_t stat;

    assign cfg.ready = 1'b1;

    egbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    egbr_datapath #(
        .BUFFER_BYTES   (BUFFER_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_mode       (req.mode),
        .in_count      (req.count),
        .in_byte_index (req.byte_index),
        .in_byte_value (req.byte_value),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.data),
        .value         (rsp.value),
        .signed_value  (rsp.signed_value),
        .exhausted     (rsp.exhausted),
        .code_error    (rsp.code_error),
        .bit_position  (rsp.bit_position),
        .bits_left     (rsp.bits_left)
    );

`ifndef SYNTHESIS
    a_no_double_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.exhausted && rsp.code_error))
        else $error("exhausted and code_error set together");

    a_one_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.signed_value != 32'sd0)) |-> (rsp.value == 32'd0))
        else $error("value and signed_value both nonzero");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while an item is in progress");
`endif

endmodule
`default_nettype wire

>>> sv/egbr_ctrl.sv
// Controller of the Exp-Golomb bit reader: sequences start, bit fetch
// and result publication. Depends on egbr_pkg.
`default_nettype none
module egbr_ctrl
    import egbr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    input  wire egbr_stat_t stat,
    output egbr_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DATA,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    cmd.start  = 1'b1;
                    state_next = stat.needs_bits ? ST_ADDR : ST_FIN;
                end
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = stat.at_end ? ST_FIN : ST_DATA;
            end
            ST_DATA: begin
                cmd.data   = 1'b1;
                state_next = stat.last_bit ? ST_FIN : ST_ADDR;
            end
            ST_FIN: begin
                if (!rsp_valid_reg || rsp_ready) begin
                    cmd.publish    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

>>> sv/egbr_datapath.sv
// Datapath of the Exp-Golomb bit reader: byte buffer, bit offset, bit
// accumulator and result registers. Depends on egbr_pkg.
`default_nettype none
module egbr_datapath
    import egbr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES   = 4096,
    parameter int unsigned MAX_FIELD_BITS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire egbr_cmd_t          cmd,
    output egbr_stat_t              stat,
    input  wire logic [2:0]         in_mode,
    input  wire logic [15:0]        in_count,
    input  wire logic [11:0]        in_byte_index,
    input  wire logic [7:0]         in_byte_value,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_data,
    output logic [31:0]             value,
    output logic signed [31:0]      signed_value,
    output logic                    exhausted,
    output logic                    code_error,
    output logic [15:0]             bit_position,
    output logic signed [16:0]      bits_left
);

    localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
    localparam int unsigned CNT_W  = $clog2(MAX_FIELD_BITS + 1);
    localparam int unsigned REM_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [15:0] CAP_BITS = 16'(BUFFER_BYTES * 8);
    localparam logic [15:0] MAX_CNT  = 16'(MAX_FIELD_BITS);
    localparam logic [11:0] BUF_LIM  = 12'(BUFFER_BYTES - 1);

    logic [7:0]          mem [BUFFER_BYTES];
    logic [15:0]         len_reg, off_reg;
    logic [15:0]         pos_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [4:0]          zeros_reg;
    logic                suffix_reg;
    logic [31:0]         acc_reg, val_reg;
    logic                exh_reg, err_reg;
    mode_t               mode_reg;
    logic [7:0]          rd_byte_reg;

    mode_t               in_mode_t;
    logic [15:0]         len_eff;
    logic                cur_bit;
    logic [15:0]         pos_inc;
    logic [31:0]         acc_shift;
    logic [31:0]         ue_value;
    logic [15:0]         adv_n;
    logic [16:0]         adv_sum;
    logic [15:0]         adv_off;
    logic                count_ok;
    logic                is_rp;
    logic                commit;
    logic [32:0]         se_half;
    logic [31:0]         se_map;

    assign in_mode_t = mode_t'(in_mode);
    assign len_eff   = (len_reg < CAP_BITS) ? len_reg : CAP_BITS;
    assign cur_bit   = rd_byte_reg[3'd7 - pos_reg[2:0]];
    assign pos_inc   = pos_reg + 16'd1;
    assign acc_shift = {acc_reg[30:0], cur_bit};
    assign ue_value  = (32'd1 << zeros_reg) - 32'd1 + acc_shift;
    assign adv_n     = (in_mode_t == MODE_SKIP) ? in_count
                                                : {13'd0, 3'(3'd0 - off_reg[2:0])};
    assign adv_sum   = {1'b0, off_reg} + {1'b0, adv_n};
    assign adv_off   = adv_sum[16] ? 16'hFFFF : adv_sum[15:0];
    assign count_ok  = (in_count != 16'd0) && (in_count <= MAX_CNT);
    assign is_rp     = (mode_reg == MODE_READ) || (mode_reg == MODE_PEEK);
    assign commit    = (mode_reg != MODE_PEEK);
    assign se_half   = ({1'b0, val_reg} + 33'd1) >> 1;
    assign se_map    = val_reg[0] ? se_half[31:0] : (32'd0 - {1'b0, val_reg[31:1]});

    always_comb begin
        stat.at_end     = (pos_reg >= len_eff);
        stat.needs_bits = (((in_mode_t == MODE_READ) || (in_mode_t == MODE_PEEK)) && count_ok)
                          || (in_mode_t == MODE_UE) || (in_mode_t == MODE_SE);
        if (is_rp || suffix_reg)
            stat.last_bit = (rem_reg == REM_W'(1));
        else if (cur_bit)
            stat.last_bit = (zeros_reg == 5'd0);
        else
            stat.last_bit = (zeros_reg == PREFIX_MAX);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            len_reg <= '0;
            off_reg <= '0;
        end
        else begin
            if (cfg_we)
                len_reg <= cfg_data;
            if (cmd.start) begin
                case (in_mode_t)
                    MODE_RESTART:          off_reg <= '0;
                    MODE_SKIP, MODE_ALIGN: off_reg <= adv_off;
                    default:               off_reg <= off_reg;
                endcase
            end
            else if (cmd.addr && stat.at_end && commit)
                off_reg <= pos_reg;
            else if (cmd.data && stat.last_bit && commit)
                off_reg <= pos_inc;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.start && (in_mode_t == MODE_LOAD) && (in_byte_index <= BUF_LIM))
            mem[in_byte_index[ADDR_W-1:0]] <= in_byte_value;
        if (cmd.addr)
            rd_byte_reg <= mem[pos_reg[ADDR_W+2:3]];
    end

    always_ff @(posedge clk) begin
        if (cmd.start) begin
            mode_reg   <= in_mode_t;
            pos_reg    <= off_reg;
            rem_reg    <= REM_W'(in_count[CNT_W-1:0]);
            zeros_reg  <= '0;
            suffix_reg <= 1'b0;
            acc_reg    <= '0;
            val_reg    <= '0;
            exh_reg    <= ((in_mode_t == MODE_SKIP) || (in_mode_t == MODE_ALIGN))
                          && (adv_sum > {1'b0, len_eff});
            err_reg    <= ((in_mode_t == MODE_READ) || (in_mode_t == MODE_PEEK))
                          && (in_count > MAX_CNT);
        end
        else if (cmd.addr) begin
            if (stat.at_end)
                exh_reg <= 1'b1;
        end
        else if (cmd.data) begin
            pos_reg <= pos_inc;
            if (is_rp) begin
                acc_reg <= acc_shift;
                rem_reg <= rem_reg - REM_W'(1);
                if (stat.last_bit)
                    val_reg <= acc_shift;
            end
            else if (suffix_reg) begin
                acc_reg <= acc_shift;
                rem_reg <= rem_reg - REM_W'(1);
                if (stat.last_bit)
                    val_reg <= ue_value;
            end
            else if (cur_bit) begin
                suffix_reg <= 1'b1;
                rem_reg    <= REM_W'(zeros_reg);
            end
            else begin
                zeros_reg <= zeros_reg + 5'd1;
                if (stat.last_bit)
                    err_reg <= 1'b1;
            end
        end
        if (cmd.publish) begin
            value        <= (mode_reg == MODE_SE) ? 32'd0 : val_reg;
            signed_value <= (mode_reg == MODE_SE) ? $signed(se_map) : 32'sd0;
            exhausted    <= exh_reg;
            code_error   <= err_reg;
            bit_position <= off_reg;
            bits_left    <= $signed({1'b0, len_eff} - {1'b0, off_reg});
        end
    end

endmodule
`default_nettype wire

>>> tb/exp_golomb_bit_reader_core_tb.sv
// Testbench for the Exp-Golomb bit reader core: directed and random request
// streams checked beat by beat against a behavioral predictor.
// Depends on egbr_pkg, egbr_if and exp_golomb_bit_reader_core.
`timescale 1ns / 100ps
module exp_golomb_bit_reader_core_tb;
    import egbr_pkg::*;

    localparam int BUF_BYTES = 4096;
    localparam int MAX_BITS = 32;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] signed_value;
        logic        exhausted;
        logic        code_error;
        logic [15:0] bit_position;
        logic [16:0] bits_left;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    egbr_req_if req ();
    egbr_rsp_if rsp ();
    egbr_cfg_if cfg ();

    exp_golomb_bit_reader_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [7:0]  model_bytes [BUF_BYTES];
    bit          written [BUF_BYTES];
    int unsigned model_offset;
    int unsigned model_length;
    reading_t    pending_readings [$];
    int          mismatches;
    int          beats_checked;
    int          send_idle_pct;
    int          stall_pct;
    int          wrote_bytes;
    int          ue_count;

    initial
    begin
        req.valid = 1'b0;
        req.mode = MODE_LOAD;
        req.count = '0;
        req.byte_index = '0;
        req.byte_value = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        #(8 * 80_000_000);
        $display("Timeout waiting for the reader.");
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned usable_bits();
        return model_length < BUF_BYTES * 8 ? model_length : BUF_BYTES * 8;
    endfunction

    function automatic bit pull_bits(inout int unsigned pos, input int unsigned n,
                                     output logic [31:0] v);
        int unsigned lim;
        lim = usable_bits();
        v = '0;
        while (n > 0)
        begin
            if (pos >= lim)
            begin
                v = '0;
                return 1'b1;
            end
            n--;
            if (model_bytes[pos >> 3][7 - (pos & 7)])
                v[n] = 1'b1;
            pos++;
        end
        return 1'b0;
    endfunction

    function automatic int decode_golomb(output logic [31:0] v);
        int unsigned zeros;
        logic [31:0] b;
        logic [31:0] suffix;
        zeros = 0;
        v = '0;
        forever
        begin
            if (pull_bits(model_offset, 1, b))
                return 1;
            if (b[0])
                break;
            zeros++;
            if (zeros > 31)
                return 2;
        end
        if (pull_bits(model_offset, zeros, suffix))
            return 1;
        v = 32'((64'd1 << zeros) - 1 + suffix);
        return 0;
    endfunction

    function automatic bit move_offset(int unsigned n);
        int unsigned s;
        s = model_offset + n;
        model_offset = s > 65535 ? 65535 : s;
        return s > usable_bits();
    endfunction

    function automatic reading_t predict_reading(mode_t m, logic [15:0] n,
                                                 logic [11:0] idx, logic [7:0] bv);
        reading_t r;
        int unsigned p;
        int rc;
        logic [31:0] k;
        r = '0;
        case (m)
            MODE_LOAD:
            begin
                model_bytes[idx] = bv;
            end
            MODE_RESTART: model_offset = 0;
            MODE_READ, MODE_PEEK:
            begin
                if (n > MAX_BITS)
                    r.code_error = 1'b1;
                else if (m == MODE_READ)
                    r.exhausted = pull_bits(model_offset, n, r.value);
                else
                begin
                    p = model_offset;
                    r.exhausted = pull_bits(p, n, r.value);
                end
            end
            MODE_SKIP: r.exhausted = move_offset(n);
            MODE_ALIGN: r.exhausted = move_offset((8 - (model_offset & 7)) & 7);
            MODE_UE:
            begin
                rc = decode_golomb(r.value);
                r.exhausted = rc == 1;
                r.code_error = rc == 2;
            end
            default:
            begin
                rc = decode_golomb(k);
                r.exhausted = rc == 1;
                r.code_error = rc == 2;
                if (rc == 0 && k != 0)
                    r.signed_value = k[0] ? 32'((64'(k) + 1) >> 1) : -(k >> 1);
            end
        endcase
        r.bit_position = model_offset[15:0];
        r.bits_left = 17'(usable_bits() - model_offset);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("Mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic send_request(mode_t m, logic [15:0] n = 0,
                                logic [11:0] idx = 0, logic [7:0] bv = 0);
        @(posedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(posedge clk);
        pending_readings.push_back(predict_reading(m, n, idx, bv));
        if (m == MODE_LOAD)
            written[idx] = 1'b1;
        req.valid <= 1'b1;
        req.mode <= m;
        req.count <= n;
        req.byte_index <= idx;
        req.byte_value <= bv;
        do
            @(posedge clk);
        while (!req.ready);
        req.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        reading_t w;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                beats_checked++;
                if (pending_readings.size() == 0)
                    report_mismatch("unexpected beat", 0, 0);
                else
                begin
                    w = pending_readings.pop_front();
                    if (rsp.value !== w.value)
                        report_mismatch("value", rsp.value, w.value);
                    if (rsp.signed_value !== w.signed_value)
                        report_mismatch("signed_value", rsp.signed_value, w.signed_value);
                    if (rsp.exhausted !== w.exhausted)
                        report_mismatch("exhausted", rsp.exhausted, w.exhausted);
                    if (rsp.code_error !== w.code_error)
                        report_mismatch("code_error", rsp.code_error, w.code_error);
                    if (rsp.bit_position !== w.bit_position)
                        report_mismatch("bit_position", rsp.bit_position, w.bit_position);
                    if (rsp.bits_left !== w.bits_left)
                        report_mismatch("bits_left", 32'(rsp.bits_left), 32'(w.bits_left));
                end
            end
            rsp.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    task automatic drain_and_idle();
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_length(int unsigned len);
        drain_and_idle();
        cfg.valid <= 1'b1;
        cfg.data <= len[15:0];
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        model_length = len & 16'hFFFF;
    endtask

    task automatic fill_bytes(int first, int num, bit zeros);
        for (int i = first; i < first + num; i++)
            send_request(MODE_LOAD, 0, i[11:0], zeros ? 8'h00 : 8'($urandom));
        if (first + num > wrote_bytes)
            wrote_bytes = first + num;
    endtask

    // Keeps reads inside the bytes that have been written.
    task automatic cap_length_to_written();
        write_length(wrote_bytes * 8);
    endtask

    task automatic test_directed();
        write_length(0);
        send_request(MODE_READ, 1);
        send_request(MODE_UE);
        fill_bytes(0, 8, 1'b1);
        send_request(MODE_LOAD, 0, 12'd0, 8'hA5);
        send_request(MODE_LOAD, 0, 12'd1, 8'h4C);
        send_request(MODE_LOAD, 0, 12'd2, 8'hFF);
        send_request(MODE_LOAD, 0, 12'd3, 8'h80);
        send_request(MODE_LOAD, 0, 12'd4095, 8'hFF);
        written[4095] = 1'b0;
        write_length(64);
        send_request(MODE_RESTART);
        send_request(MODE_PEEK, 0);
        send_request(MODE_READ, 3);
        send_request(MODE_ALIGN);
        send_request(MODE_UE);
        send_request(MODE_SE);
        send_request(MODE_SE);
        send_request(MODE_PEEK, 33);
        send_request(MODE_READ, 16'hFFFF);
        send_request(MODE_RESTART);
        send_request(MODE_READ, 32);
        send_request(MODE_UE);
        send_request(MODE_UE);
        send_request(MODE_READ, 32);
        send_request(MODE_SKIP, 16'hFFFF);
        send_request(MODE_ALIGN);
    endtask

    task automatic test_random(int items);
        int r;
        int k;
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                fill_bytes($urandom_range(wrote_bytes - 1), 1, 1'b0);
            else if (r < 8)
                send_request(MODE_RESTART);
            else if (r < 22)
            begin
                k = $urandom_range(99) < 85 ? $urandom_range(MAX_BITS) : $urandom;
                send_request(MODE_READ, 16'(k));
            end
            else if (r < 32)
                send_request(MODE_PEEK, 16'($urandom_range(99) < 85
                                            ? $urandom_range(MAX_BITS) : $urandom));
            else if (r < 38)
                send_request(MODE_SKIP, 16'($urandom_range(99) < 80
                                            ? $urandom_range(40) : $urandom));
            else if (r < 44)
                send_request(MODE_ALIGN);
            else if (r < 72)
            begin
                send_request(MODE_UE);
                ue_count++;
            end
            else
            begin
                send_request(MODE_SE);
                ue_count++;
            end
        end
    endtask

    task automatic test_long_prefix();
        fill_bytes(0, 6, 1'b1);
        send_request(MODE_LOAD, 0, 12'd6, 8'hFF);
        cap_length_to_written();
        send_request(MODE_RESTART);
        send_request(MODE_UE);
        send_request(MODE_RESTART);
        send_request(MODE_SKIP, 16'd8);
        send_request(MODE_SE);
    endtask

    task automatic run_phase(int idle, int stall, int items, int nbytes);
        drain_and_idle();
        send_idle_pct = idle;
        stall_pct = stall;
        fill_bytes(0, nbytes, 1'b0);
        for (int j = 0; j < 3; j++)
            send_request(MODE_LOAD, 0, 12'($urandom_range(nbytes - 1)), 8'($urandom_range(3)));
        write_length($urandom_range(1) ? nbytes * 8 : $urandom_range(nbytes * 8));
        send_request(MODE_RESTART);
        test_random(items);
    endtask

    initial
    begin
        mismatches = 0;
        beats_checked = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        wrote_bytes = 0;
        ue_count = 0;
        model_offset = 0;
        model_length = 0;
        foreach (model_bytes[i])
        begin
            model_bytes[i] = '0;
            written[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_prefix();
        run_phase(0, 0, 270, 64);
        run_phase(49, 0, 270, 48);
        run_phase(0, 49, 270, 64);
        run_phase(12, 12, 270, 32);
        drain_and_idle();
        send_idle_pct = 0;
        stall_pct = 0;
        fill_bytes(0, 16, 1'b0);
        write_length(16'hFFFF);
        write_length(wrote_bytes * 8);
        send_request(MODE_SKIP, 16'hFFFF);
        send_request(MODE_SKIP, 16'd1);
        send_request(MODE_RESTART);
        drain_and_idle();
        $display("Checked %0d response beats, %0d Exp-Golomb decodes, four idle patterns.",
                 beats_checked, ue_count);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> files.f
sv/egbr_pkg.sv
sv/egbr_if.sv
sv/egbr_ctrl.sv
sv/egbr_datapath.sv
sv/exp_golomb_bit_reader_core.sv
tb/exp_golomb_bit_reader_core_tb.sv
